@@ rtl/core/lpst_pkg.sv @@
// Shared types and constants for the linear-probe slot table.
// Used by the channel interfaces and the core; depends on nothing else.
package lpst_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned HASH_W   = 64;
    localparam int unsigned SIZE_W   = 7;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned BITCNT_W = $clog2(HASH_W);

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

endpackage

@@ rtl/core/lpst_in_if.sv @@
// Request channel of the linear-probe slot table: valid/ready plus payload.
// Depends on lpst_pkg for the field widths.
interface lpst_in_if import lpst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [KEY_W-1:0]  key_id;
    logic [HASH_W-1:0] key_hash;

    modport source (output valid, action, key_id, key_hash, input ready);
    modport sink   (input valid, action, key_id, key_hash, output ready);
endinterface

@@ rtl/core/lpst_out_if.sv @@
// Result channel of the linear-probe slot table: valid/ready plus payload.
// Depends on lpst_pkg for the field widths.
interface lpst_out_if import lpst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    t_status           status;

    modport source (output valid, slot, status, input ready);
    modport sink   (input valid, slot, status, output ready);
endinterface

@@ rtl/core/lpst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lpst_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/linear_probe_slot_table_core.sv @@
// Top level of the linear-probe slot table: sequencer, shared modulo unit
// and probe logic. Depends on lpst_pkg, lpst_in_if, lpst_out_if and lpst_ram.
//
// Usage:
// The table holds key ids in a ring of table_size slots (capped at
// TABLE_DEPTH). A request transaction on i_in carries an action (insert or
// lookup), a 32-bit key id and a 64-bit hash. Every request that no write of
// table_size interrupts produces exactly one result transaction on o_out
// carrying a slot number and a status. The start slot is the hash modulo
// the ring size, computed by a restoring remainder unit one hash bit per
// cycle. The probe then reads one slot per cycle from the slot RAM; because
// the RAM read is registered, the compare works on the word read in the
// cycle before. A request passes through the remainder, the probe and the
// result state; the ring size zero skips the remainder and probe and goes
// straight to the result.
// i_in.ready is high only while the sequencer is idle. The result waits in
// the output register while the receiver stalls; a new request is taken
// meanwhile, and its own result waits in the sequencer until that register
// frees up. Reset, and every write of table_size, start a clearing pass
// that writes every slot and empties every occupancy mark; no request is
// taken during that pass.
module linear_probe_slot_table_core
    import lpst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    lpst_in_if.sink           i_in,
    lpst_out_if.source        o_out
);

    localparam int unsigned IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned RING_CAP  = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
    localparam int unsigned RAM_W     = KEY_W + 1;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_PROBE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_table_size, n_table_size;
    logic [IDX_W-1:0]    r_clr_addr, n_clr_addr;
    logic                r_cmp_v, n_cmp_v;
    logic                r_out_valid, n_out_valid;

    logic                r_action, n_action;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [SIZE_W-1:0]   r_rem, n_rem;
    logic [BITCNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [SIZE_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]   r_iss_cnt, n_iss_cnt;
    logic [SIZE_W-1:0]   r_cmp_pos, n_cmp_pos;
    logic                r_cmp_last, n_cmp_last;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    t_status             r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    t_status             r_out_status, n_out_status;

    logic [SIZE_W-1:0]   ring;
    logic [SIZE_W:0]     rem_shift;
    logic [SIZE_W:0]     rem_step;
    logic [SIZE_W:0]     pos_inc;
    logic [SIZE_W-1:0]   pos_next;
    logic                in_fire;
    logic                out_free;
    logic                hit;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;

    // Each RAM word holds the occupancy mark above the stored key.
    lpst_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (IDX_W'(r_pos)),
        .o_rdata (ram_rdata)
    );

    // Effective ring size: the register saturated to the storage depth.
    assign ring = (r_table_size > SIZE_W'(RING_CAP)) ? SIZE_W'(RING_CAP) : r_table_size;

    // Restoring remainder step: bring in the next hash bit, subtract if it fits.
    assign rem_shift = {r_rem, r_hash[HASH_W-1]};
    assign rem_step  = (rem_shift >= {1'b0, ring}) ? (rem_shift - {1'b0, ring}) : rem_shift;

    // Next probe position with wrap at the ring size.
    assign pos_inc  = {1'b0, r_pos} + (SIZE_W+1)'(1);
    assign pos_next = (pos_inc >= {1'b0, ring}) ? '0 : pos_inc[SIZE_W-1:0];

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // An insert stops at the first free slot, a lookup at the first used
    // slot holding an equal key.
    assign hit = (r_action == ACT_INSERT) ? !ram_rdata[KEY_W]
               : (ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == r_key));

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.slot   = r_out_slot;
    assign o_out.status = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_table_size = r_table_size;
        n_clr_addr   = r_clr_addr;
        n_cmp_v      = r_cmp_v;
        n_action     = r_action;
        n_key        = r_key;
        n_hash       = r_hash;
        n_rem        = r_rem;
        n_bit_cnt    = r_bit_cnt;
        n_pos        = r_pos;
        n_iss_cnt    = r_iss_cnt;
        n_cmp_pos    = r_cmp_pos;
        n_cmp_last   = r_cmp_last;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = r_clr_addr;
        ram_wdata    = '0;

        case (r_state)
            S_CLEAR: begin
                // Sweep the RAM writing empty words, one slot per cycle.
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_action  = i_in.action;
                    n_key     = i_in.key_id;
                    n_hash    = i_in.key_hash;
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    if (ring == '0) begin
                        n_res_slot   = '0;
                        n_res_status = (i_in.action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_hash    = r_hash << 1;
                n_rem     = rem_step[SIZE_W-1:0];
                n_bit_cnt = r_bit_cnt + BITCNT_W'(1);
                if (r_bit_cnt == BITCNT_W'(HASH_W - 1)) begin
                    n_pos     = rem_step[SIZE_W-1:0];
                    n_iss_cnt = '0;
                    n_cmp_v   = 1'b0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                // Issue one read per cycle until every ring slot was read.
                if (r_iss_cnt != ring) begin
                    n_pos      = pos_next;
                    n_iss_cnt  = r_iss_cnt + SIZE_W'(1);
                    n_cmp_v    = 1'b1;
                    n_cmp_pos  = r_pos;
                    n_cmp_last = (r_iss_cnt == (ring - SIZE_W'(1)));
                end else begin
                    n_cmp_v = 1'b0;
                end
                // Compare the word read in the previous cycle.
                if (r_cmp_v) begin
                    if (hit) begin
                        n_res_slot   = r_cmp_pos[SLOT_W-1:0];
                        n_res_status = ST_OK;
                        n_cmp_v      = 1'b0;
                        n_state      = S_EMIT;
                        if (r_action == ACT_INSERT) begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(r_cmp_pos);
                            ram_wdata = {1'b1, r_key};
                        end
                    end else if (r_cmp_last) begin
                        n_res_slot   = '0;
                        n_res_status = (r_action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        n_cmp_v      = 1'b0;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_clr_addr = '0;
                n_state    = S_CLEAR;
            end
        endcase

        // A size write restarts the clearing pass.
        if (i_cfg_wr_en) begin
            n_table_size = i_cfg_wr_data;
            n_clr_addr   = '0;
            n_cmp_v      = 1'b0;
            n_state      = S_CLEAR;
        end
    end

    // Output register: loads the pending result when it is free.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_EMIT) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_slot   = r_res_slot;
            n_out_status = r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_table_size <= '0;
            r_clr_addr   <= '0;
            r_cmp_v      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_table_size <= n_table_size;
            r_clr_addr   <= n_clr_addr;
            r_cmp_v      <= n_cmp_v;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_rem        <= n_rem;
        r_bit_cnt    <= n_bit_cnt;
        r_pos        <= n_pos;
        r_iss_cnt    <= n_iss_cnt;
        r_cmp_pos    <= n_cmp_pos;
        r_cmp_last   <= n_cmp_last;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    // An accepted request goes to the remainder unit or straight to a result.
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_cfg_wr_en |=> (r_state == S_MOD) || (r_state == S_EMIT))
        else $error("request not followed by remainder or result");

    // A new result appears only when the sequencer had one pending.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the result state");

    // The probe position stays inside the ring.
    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_pos < ring))
        else $error("probe position outside the ring");

    // The slot RAM is never written while the sequencer is idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("slot RAM written while idle");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for linear_probe_slot_table_core: directed table, then random phases.
// Uses lpst_pkg, lpst_in_if and lpst_out_if from the RTL; results are predicted locally.
module tb import lpst_pkg::*; ();

    localparam int TABLE_DEPTH     = 64;
    localparam int RANDOM_ITEMS    = 650;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int TAIL_CYCLES     = 150;
    // The receiver stops taking results once this many requests have gone in.
    localparam int HOLDOFF_AT_ITEM = 120;
    localparam int HOLDOFF_CYCLES  = 600;
    // The sender waits for every outstanding result at this point, size unchanged.
    localparam int PAUSE_AT_ITEM   = 300;
    // Inside this window of the request count the sender adds no random gaps and ready stays high.
    localparam int QUIET_FROM      = 450;
    localparam int QUIET_TO        = 560;

    typedef enum logic {ROW_SIZE, ROW_REQ} t_row_kind;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_table_result;

    // One row of the directed table. A ROW_SIZE row writes table_size. A ROW_REQ row sends
    // one request; when typed is set, the expected result is the one written in the row,
    // otherwise it comes from the predictor.
    typedef struct packed {
        t_row_kind         kind;
        logic [SIZE_W-1:0] size;
        logic              act;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic              typed;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_row;

    localparam int NUM_DIRECTED = 26;
    localparam logic [HASH_W-1:0] HASH_ONES = '1;

    t_row directed_rows [NUM_DIRECTED] = '{
        // Ring size zero straight after reset: lookups miss, inserts report full.
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0000, 64'h0,   1'b1, 6'd0,  ST_NOT_FOUND},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'hFFFF_FFFF, HASH_ONES, 1'b1, 6'd0, ST_FULL},
        // A single slot: the first insert takes it, the second finds the ring full.
        '{ROW_SIZE, 7'd1,   ACT_INSERT, 32'h0,         64'h0,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'hFFFF_FFFF, HASH_ONES, 1'b1, 6'd0, ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_0000, 64'h0,   1'b1, 6'd0,  ST_FULL},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF,
          1'b1, 6'd0, ST_OK},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0000, 64'h0,   1'b1, 6'd0,  ST_NOT_FOUND},
        // An oversized ring saturates to the full depth; the all-ones hash starts at 63.
        '{ROW_SIZE, 7'd127, ACT_INSERT, 32'h0,         64'h0,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_0005, HASH_ONES, 1'b1, 6'd63, ST_OK},
        // A duplicate key takes a new slot, wrapping from the top back to slot 0.
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_0005, 64'd63,  1'b1, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0005, 64'd0,   1'b1, 6'd0,  ST_OK},
        // Starting at slot 1 the probe skips free slots and finds the copy in slot 63.
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0005, 64'd1,   1'b1, 6'd63, ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'hA5A5_5A5A, 64'h40,  1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0007, 64'h8000_0000_0000_0000,
          1'b1, 6'd0, ST_NOT_FOUND},
        // Rewriting the size clears every mark, so the old keys are stale and never seen.
        '{ROW_SIZE, 7'd64,  ACT_INSERT, 32'h0,         64'h0,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_0005, 64'd63,  1'b1, 6'd0,  ST_NOT_FOUND},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000,
          1'b1, 6'd0, ST_OK},
        '{ROW_SIZE, 7'd65,  ACT_INSERT, 32'h0,         64'h0,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h1234_5678, 64'hFFFF_FFFF_0000_0041,
          1'b0, 6'd0, ST_OK},
        // A three-slot ring filled up, then one insert too many.
        '{ROW_SIZE, 7'd3,   ACT_INSERT, 32'h0,         64'h0,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_000B, HASH_ONES, 1'b0, 6'd0, ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_000C, 64'd2,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_000D, 64'd2,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_INSERT, 32'h0000_000E, 64'd0,   1'b1, 6'd0,  ST_FULL},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_000D, 64'd1,   1'b0, 6'd0,  ST_OK},
        '{ROW_REQ,  7'd0,   ACT_LOOKUP, 32'h0000_000E, 64'd2,   1'b1, 6'd0,  ST_NOT_FOUND}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [SIZE_W-1:0] i_cfg_wr_data;

    lpst_in_if  req_if ();
    lpst_out_if rsp_if ();

    linear_probe_slot_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (req_if.sink),
        .o_out         (rsp_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the table: stored keys, occupancy marks and the size register.
    logic [KEY_W-1:0]  stored_key [TABLE_DEPTH];
    bit                slot_taken [TABLE_DEPTH];
    logic [SIZE_W-1:0] ring_cfg;

    // Results still owed by the block, oldest first.
    t_table_result pending_results [$];
    int            mismatch_count = 0;
    int            requests_taken = 0;
    int            cycle_count    = 0;

    function automatic bit quiet_window();
        return requests_taken >= QUIET_FROM && requests_taken < QUIET_TO;
    endfunction

    // Apply one request to the local table and return the result it must produce.
    // The ring is capped at the table depth; a zero ring leaves the miss or full status.
    function automatic t_table_result probe_table(input logic act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [HASH_W-1:0] hash);
        t_table_result     res;
        int                ring;
        int                pos;
        logic [HASH_W-1:0] ring_len;
        res.slot   = '0;
        res.status = (act == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        ring       = (ring_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(ring_cfg);
        if (ring != 0) begin
            ring_len = HASH_W'(ring);
            pos      = int'(hash % ring_len);
            for (int n = 0; n < ring; n++) begin
                if (act == ACT_INSERT) begin
                    if (!slot_taken[pos]) begin
                        slot_taken[pos] = 1'b1;
                        stored_key[pos] = key;
                        res.slot        = pos[SLOT_W-1:0];
                        res.status      = ST_OK;
                        break;
                    end
                end else if (slot_taken[pos] && stored_key[pos] == key) begin
                    res.slot   = pos[SLOT_W-1:0];
                    res.status = ST_OK;
                    break;
                end
                pos = (pos + 1 >= ring) ? 0 : pos + 1;
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Hold the request channel quiet until every outstanding result has been taken.
    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // The block must be idle for a size write, so drain first. The write also clears
    // every local occupancy mark; the block's own clearing pass holds off the next request.
    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        wait_all_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ring_cfg = value;
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    endtask

    // Offer one request, after a random gap now and then, and wait until it is taken.
    // The gaps are long enough to be felt next to the block's own busy time.
    // The prediction is made at acceptance so that the local table follows the block's order.
    task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                                input logic [HASH_W-1:0] hash, input logic typed,
                                input t_table_result typed_result);
        t_table_result predicted;
        int            gap;
        if (!quiet_window() && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, 4 * TABLE_DEPTH);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.key_id   <= key;
        req_if.key_hash <= hash;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = probe_table(act, key, hash);
        pending_results.push_back(typed ? typed_result : predicted);
        requests_taken++;
    endtask

    // Stimulus: reset, the directed table, then random phases, each one behind a size write.
    initial begin
        int                random_items;
        int                phase_len;
        int                phase_count;
        int                pick;
        logic [SIZE_W-1:0] size_pick;
        logic              act;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key_pool [$];

        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        req_if.valid    <= 1'b0;
        req_if.action   <= ACT_INSERT;
        req_if.key_id   <= '0;
        req_if.key_hash <= '0;
        ring_cfg = '0;
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        foreach (stored_key[i]) stored_key[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SIZE) begin
                write_table_size(directed_rows[i].size);
            end else begin
                send_request(directed_rows[i].act, directed_rows[i].key,
                             directed_rows[i].hash, directed_rows[i].typed,
                             '{directed_rows[i].slot, directed_rows[i].status});
            end
        end

        // Most phases use small rings so that they fill up and report full; a few use
        // the whole depth, an oversized value, or zero.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(9);
            case (pick)
                0: begin
                    size_pick = 7'd0;
                end
                1: begin
                    size_pick = 7'd1;
                end
                2: begin
                    size_pick = 7'd64;
                end
                3: begin
                    size_pick = SIZE_W'($urandom_range(65, 127));
                end
                4: begin
                    size_pick = 7'd127;
                end
                default: begin
                    size_pick = SIZE_W'($urandom_range(2, 16));
                end
            endcase
            write_table_size(size_pick);
            key_pool.delete();
            phase_len   = $urandom_range(40, 80);
            phase_count = 0;
            // A phase never ends while the receiver hold-off is starting, so the sender
            // keeps offering requests into a block that has filled up.
            while (random_items < RANDOM_ITEMS &&
                   (phase_count < phase_len ||
                    (requests_taken >= HOLDOFF_AT_ITEM &&
                     requests_taken < HOLDOFF_AT_ITEM + 6))) begin
                if (key_pool.size() == 0 || $urandom_range(99) < 45) begin
                    act  = ACT_INSERT;
                    pick = $urandom_range(99);
                    if (pick < 70 || key_pool.size() == 0) begin
                        key = $urandom;
                    end else if (pick < 90) begin
                        key = key_pool[$urandom_range(key_pool.size() - 1)];
                    end else begin
                        key = $urandom_range(15);
                    end
                    key_pool.push_back(key);
                end else begin
                    act = ACT_LOOKUP;
                    if ($urandom_range(99) < 60) begin
                        key = key_pool[$urandom_range(key_pool.size() - 1)];
                    end else begin
                        key = $urandom;
                    end
                end
                if ($urandom_range(99) < 20) begin
                    hash = HASH_W'($urandom_range(200));
                end else begin
                    hash = {$urandom, $urandom};
                end
                send_request(act, key, hash, 1'b0, '0);
                phase_count++;
                random_items++;
                if (requests_taken == PAUSE_AT_ITEM) begin
                    wait_all_results();
                end
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: compare each transaction with the oldest expectation, then choose
    // ready for the next cycle. One long hold-off lets the block fill up and stall its
    // input; inside the quiet window ready stays high.
    initial begin
        t_table_result want;
        int            holdoff_left;
        bit            holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result slot %0d status %0d with nothing pending",
                                            rsp_if.slot, rsp_if.status));
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.slot !== want.slot) begin
                        flag_mismatch($sformatf("slot %0d, expected %0d",
                                                rsp_if.slot, want.slot));
                    end
                    if (rsp_if.status !== want.status) begin
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                rsp_if.status, want.status));
                    end
                end
            end
            if (!holdoff_done && requests_taken >= HOLDOFF_AT_ITEM) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_if.ready <= 1'b0;
            end else if (quiet_window()) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

endmodule

@@ linear_probe_slot_table_core.f @@
rtl/core/lpst_pkg.sv
rtl/core/lpst_in_if.sv
rtl/core/lpst_out_if.sv
rtl/core/lpst_ram.sv
rtl/core/linear_probe_slot_table_core.sv
bench/tb.sv
